FILE: sv/rbfp_pkg.sv
// ----------------------------------------------------------------------------
// rbfp_pkg: shared definitions for the ranked best-fit placer
// Slot table sizes, field widths, command codes and the records that travel
// between the control logic and the row of host cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rbfp_pkg;

    // Table geometry
    localparam int HOST_SLOTS  = 64;
    localparam int RANK_LEVELS = 16;

    localparam int SLOT_W  = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
    localparam int IDX_W   = (SLOT_W > 6) ? SLOT_W : 6;
    localparam int RANK_W  = $clog2(RANK_LEVELS);
    localparam int RANK_WX = (RANK_W > 4) ? RANK_W : 4;
    localparam int CNT_W   = $clog2(HOST_SLOTS + 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int SIDX_W = 6;
    localparam int SRNK_W = 4;
    localparam int CPU_W  = 40;
    localparam int MEM_W  = 24;
    localparam int ID_W   = 16;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 24;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLACE = 2'd2;

    // Best candidate handed from cell to cell during a scan
    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] rank;
        logic [CPU_W-1:0]  slack;
        logic [IDX_W-1:0]  idx;
    } best_t;

    // Demand of the request under scan
    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic [MEM_W-1:0] mem;
    } req_t;

    // Table write broadcast to all cells
    typedef struct packed {
        logic              clear;
        logic              load;
        logic              upd;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
        logic              on;
        logic [CPU_W-1:0]  cpu;
        logic [MEM_W-1:0]  mem;
    } host_wr_t;

    // Clamp a loaded rank to the top rank level
    function automatic logic [RANK_W-1:0] sat_rank(input logic [SRNK_W-1:0] r);
        logic [RANK_WX-1:0] wide;
        wide = RANK_WX'(r);
        if (wide > RANK_WX'(RANK_LEVELS - 1)) begin
            return RANK_W'(RANK_LEVELS - 1);
        end
        return wide[RANK_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/rbfp_cell.sv
// ----------------------------------------------------------------------------
// rbfp_cell: one host slot of the placement row
// Holds the slot's rank, active flag and free capacities, and compares its
// own fit against the best candidate handed in by the previous cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rbfp_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [rbfp_pkg::IDX_W-1:0] cell_idx,
    input  wire rbfp_pkg::host_wr_t      host_wr,
    input  wire rbfp_pkg::req_t          req,
    input  wire rbfp_pkg::best_t         best_in,
    output rbfp_pkg::best_t              best_out
);
    import rbfp_pkg::*;

    logic              valid_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              on_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [MEM_W-1:0]  mem_reg;
    best_t             best_reg;
    best_t             best_next;

    logic              hit;
    logic              fits;
    logic [CPU_W-1:0]  slack;
    logic              better;

    assign hit = (host_wr.idx == cell_idx);

    // Valid bit: clear drops it, a load to this slot sets it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (host_wr.clear) begin
            valid_reg <= 1'b0;
        end else if (host_wr.load && hit) begin
            valid_reg <= 1'b1;
        end
    end

    // Slot contents: load overwrites, a placement takes the demand off
    always_ff @(posedge aclk) begin
        if (host_wr.load && hit) begin
            rank_reg <= host_wr.rank;
            on_reg   <= host_wr.on;
            cpu_reg  <= host_wr.cpu;
            mem_reg  <= host_wr.mem;
        end else if (host_wr.upd && hit) begin
            cpu_reg  <= cpu_reg - req.cpu;
            mem_reg  <= mem_reg - req.mem;
        end
    end

    // Compare own fit with the incoming candidate; ties keep the lower slot
    always_comb begin
        fits   = valid_reg && on_reg && (cpu_reg >= req.cpu) && (mem_reg >= req.mem);
        slack  = cpu_reg - req.cpu;
        better = fits && (!best_in.found || (rank_reg < best_in.rank) ||
                          ((rank_reg == best_in.rank) && (slack < best_in.slack)));
        if (better) begin
            best_next.found = 1'b1;
            best_next.rank  = rank_reg;
            best_next.slack = slack;
            best_next.idx   = cell_idx;
        end else begin
            best_next = best_in;
        end
    end

    // Hand the candidate to the next cell
    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

    assign best_out = best_reg;

endmodule

`default_nettype wire

FILE: sv/ranked_best_fit_placer_core.sv
// ----------------------------------------------------------------------------
// ranked_best_fit_placer_core: rank-first best-fit VM placement
// Slot table held in a row of host cells; a candidate record walks the row.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one beat per command. s_tuser carries the command:
//   clear the table, load a host slot, or place a VM. Other codes are dropped.
//   Clear and load take effect in the cycle the beat is accepted and produce
//   no result beat. A place beat starts a scan: the best candidate moves one
//   cell per cycle through HOST_SLOTS cells; once the last cell holds the
//   result and the output register is free, it is registered onto m_* and
//   the chosen slot's capacities are reduced at that same edge. s_tready
//   stays low during the scan and is high again once the result is
//   registered; a clear or load leaves s_tready high.
//   Output stream (m_*): one beat per place request. The result sits in an
//   output register; a new command is taken while it waits. If the receiver
//   still holds the previous result when a scan ends, the scan holds until
//   the output register frees up.
//   Reset (aresetn low, synchronous) empties the table and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ranked_best_fit_placer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // slot_index[5:0], slot_rank[9:6], slot_active[10], slot_cpu_free[50:11],
    // slot_mem_free[74:51], req_id[90:75], req_cpu[130:91], req_mem[154:131]
    input  wire logic [rbfp_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [rbfp_pkg::CMD_W-1:0]     s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // out_id[15:0], placed[16], chosen_slot[22:17]
    output      logic [rbfp_pkg::M_TDATA_W-1:0] m_tdata
);
    import rbfp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Input field unpack
    logic [SIDX_W-1:0] in_slot_index;
    logic [SRNK_W-1:0] in_slot_rank;
    logic              in_slot_active;
    logic [CPU_W-1:0]  in_slot_cpu;
    logic [MEM_W-1:0]  in_slot_mem;
    logic [ID_W-1:0]   in_req_id;
    logic [CPU_W-1:0]  in_req_cpu;
    logic [MEM_W-1:0]  in_req_mem;

    assign in_slot_index  = s_tdata[5:0];
    assign in_slot_rank   = s_tdata[9:6];
    assign in_slot_active = s_tdata[10];
    assign in_slot_cpu    = s_tdata[50:11];
    assign in_slot_mem    = s_tdata[74:51];
    assign in_req_id      = s_tdata[90:75];
    assign in_req_cpu     = s_tdata[130:91];
    assign in_req_mem     = s_tdata[154:131];

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  id_reg;
    req_t             req_reg;

    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  m_id_reg;
    logic             m_placed_reg;
    logic [SIDX_W-1:0] m_slot_reg;

    logic             accept;
    logic             scan_done;
    logic             finish;
    host_wr_t         host_wr;
    best_t            chain [HOST_SLOTS+1];
    best_t            best_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign scan_done = (state_reg == ST_SCAN) && (cnt_reg == CNT_W'(HOST_SLOTS));
    assign finish    = scan_done && (!m_valid_reg || m_tready);
    assign best_last = chain[HOST_SLOTS];

    // Sequence: idle until a place beat, then count the scan through the row
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == CMD_PLACE)) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end else if (!scan_done) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the request for the whole scan
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == CMD_PLACE)) begin
            id_reg      <= in_req_id;
            req_reg.cpu <= in_req_cpu;
            req_reg.mem <= in_req_mem;
        end
    end

    // Broadcast table writes: clear, load, and the capacity update on finish
    always_comb begin
        host_wr.clear = accept && (s_tuser == CMD_CLEAR);
        host_wr.load  = accept && (s_tuser == CMD_LOAD);
        host_wr.upd   = finish && best_last.found;
        host_wr.idx   = host_wr.upd ? best_last.idx : IDX_W'(in_slot_index);
        host_wr.rank  = sat_rank(in_slot_rank);
        host_wr.on    = in_slot_active;
        host_wr.cpu   = in_slot_cpu;
        host_wr.mem   = in_slot_mem;
    end

    // Row of host cells; the first cell sees an empty candidate
    assign chain[0] = '0;

    for (genvar g = 0; g < HOST_SLOTS; g++) begin : g_cell
        rbfp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .host_wr  (host_wr),
            .req      (req_reg),
            .best_in  (chain[g]),
            .best_out (chain[g+1])
        );
    end

    // Output register: load on finish, drop on a taken beat
    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_id_reg     <= id_reg;
            m_placed_reg <= best_last.found;
            m_slot_reg   <= best_last.found ? best_last.idx[SIDX_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_slot_reg, m_placed_reg, m_id_reg};

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ranked_best_fit_placer_core
// Streams clear, load and place beats into the core, mirrors the slot table
// in a local model to work out each placement, and checks every result beat
// against it under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;

    import rbfp_pkg::*;

    // Code the core drops without effect
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 2 * HOST_SLOTS + 20;
    localparam int PHASE_ITEMS    = 410;

    // One command beat, split into its fields
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIDX_W-1:0] idx;
        logic [SRNK_W-1:0] rank;
        logic              active;
        logic [CPU_W-1:0]  cpu;
        logic [MEM_W-1:0]  mem;
        logic [ID_W-1:0]   id;
        logic [CPU_W-1:0]  req_cpu;
        logic [MEM_W-1:0]  req_mem;
    } host_cmd_t;

    // One placement answer
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              placed;
        logic [SIDX_W-1:0] slot;
    } placement_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Mirror of the slot table
    logic              tbl_valid [HOST_SLOTS] = '{default: 1'b0};
    logic [SRNK_W-1:0] tbl_rank  [HOST_SLOTS] = '{default: '0};
    logic              tbl_on    [HOST_SLOTS] = '{default: 1'b0};
    logic [CPU_W-1:0]  tbl_cpu   [HOST_SLOTS] = '{default: '0};
    logic [MEM_W-1:0]  tbl_mem   [HOST_SLOTS] = '{default: '0};

    host_cmd_t   pending_beats[$];
    placement_t  placements[$];
    host_cmd_t   beat_on_bus;
    int          queued_items  = 0;
    int          accepted_beats = 0;
    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    ranked_best_fit_placer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random value of at most w bits
    function automatic logic [CPU_W-1:0] rnd_bits(input int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (w < 64) begin
            r = r & ((64'd1 << w) - 64'd1);
        end
        return r[CPU_W-1:0];
    endfunction

    function automatic host_cmd_t random_beat();
        host_cmd_t c;
        c.cmd     = CMD_UNUSED;
        c.idx     = SIDX_W'($urandom);
        c.rank    = SRNK_W'($urandom);
        c.active  = 1'($urandom);
        c.cpu     = rnd_bits(CPU_W);
        c.mem     = MEM_W'(rnd_bits(MEM_W));
        c.id      = ID_W'($urandom);
        c.req_cpu = rnd_bits(CPU_W);
        c.req_mem = MEM_W'(rnd_bits(MEM_W));
        return c;
    endfunction

    // Update the mirrored table and work out the placement, if any
    function automatic void apply_to_table(input host_cmd_t c);
        logic              found;
        int                best;
        logic [SRNK_W-1:0] lead_rank;
        logic [CPU_W-1:0]  lead_slack;
        logic [CPU_W-1:0]  slack;
        placement_t        res;
        found      = 1'b0;
        best       = 0;
        lead_rank  = '0;
        lead_slack = '0;
        case (c.cmd)
            CMD_CLEAR: begin
                foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            end
            CMD_LOAD: begin
                if (int'(c.idx) < HOST_SLOTS) begin
                    tbl_valid[c.idx] = 1'b1;
                    tbl_rank[c.idx]  = (int'(c.rank) >= RANK_LEVELS) ?
                                       SRNK_W'(RANK_LEVELS - 1) : c.rank;
                    tbl_on[c.idx]    = c.active;
                    tbl_cpu[c.idx]   = c.cpu;
                    tbl_mem[c.idx]   = c.mem;
                end
            end
            CMD_PLACE: begin
                // Rank first, then tightest CPU fit, then lowest slot
                for (int i = 0; i < HOST_SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_on[i] && tbl_cpu[i] >= c.req_cpu &&
                        tbl_mem[i] >= c.req_mem) begin
                        slack = tbl_cpu[i] - c.req_cpu;
                        if (!found || tbl_rank[i] < lead_rank ||
                            (tbl_rank[i] == lead_rank && slack < lead_slack)) begin
                            found      = 1'b1;
                            best       = i;
                            lead_rank  = tbl_rank[i];
                            lead_slack = slack;
                        end
                    end
                end
                res.id = c.id;
                if (found) begin
                    tbl_cpu[best] = tbl_cpu[best] - c.req_cpu;
                    tbl_mem[best] = tbl_mem[best] - c.req_mem;
                    res.placed    = 1'b1;
                    res.slot      = SIDX_W'(best);
                end else begin
                    res.placed = 1'b0;
                    res.slot   = '0;
                end
                placements = {placements, res};
            end
            default: begin
            end
        endcase
    endfunction

    task automatic add_cmd(input logic [CMD_W-1:0] cmd);
        host_cmd_t c;
        c     = random_beat();
        c.cmd = cmd;
        pending_beats = {pending_beats, c};
        if (cmd != CMD_UNUSED) begin
            queued_items++;
        end
    endtask

    task automatic add_load(input int idx, input int rank, input bit on,
                            input logic [CPU_W-1:0] cpu, input logic [MEM_W-1:0] mem);
        host_cmd_t c;
        c        = random_beat();
        c.cmd    = CMD_LOAD;
        c.idx    = SIDX_W'(idx);
        c.rank   = SRNK_W'(rank);
        c.active = on;
        c.cpu    = cpu;
        c.mem    = mem;
        pending_beats = {pending_beats, c};
        queued_items++;
    endtask

    task automatic add_place(input logic [ID_W-1:0] id, input logic [CPU_W-1:0] cpu,
                             input logic [MEM_W-1:0] mem);
        host_cmd_t c;
        c         = random_beat();
        c.cmd     = CMD_PLACE;
        c.id      = id;
        c.req_cpu = cpu;
        c.req_mem = mem;
        pending_beats = {pending_beats, c};
        queued_items++;
    endtask

    // One table fill followed by a run of requests, with some noise mixed in
    task automatic add_episode();
        int cw;
        int mw;
        int dw;
        int rank_top;
        int nload;
        int nplace;
        int pick;
        cw       = $urandom_range(1, CPU_W);
        mw       = $urandom_range(1, MEM_W);
        rank_top = ($urandom_range(1) != 0) ? RANK_LEVELS - 1 : $urandom_range(0, 2);
        if ($urandom_range(3) != 0) begin
            add_cmd(CMD_CLEAR);
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            nload = 0;
        end else if (pick == 1) begin
            nload = HOST_SLOTS;
        end else begin
            nload = $urandom_range(1, 12);
        end
        for (int k = 0; k < nload; k++) begin
            add_load((pick == 1) ? k : $urandom_range(0, HOST_SLOTS - 1),
                     $urandom_range(0, rank_top), $urandom_range(9) != 0,
                     rnd_bits(cw), MEM_W'(rnd_bits(mw)));
        end
        nplace = $urandom_range(2, 12);
        for (int k = 0; k < nplace; k++) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
                add_cmd(CMD_UNUSED);
            end else if (pick == 1) begin
                add_load($urandom_range(0, HOST_SLOTS - 1), $urandom_range(0, rank_top),
                         1'b1, rnd_bits(cw), MEM_W'(rnd_bits(mw)));
            end
            dw = cw - $urandom_range(0, 2);
            if (dw < 0) begin
                dw = 0;
            end
            add_place(ID_W'($urandom), rnd_bits(dw),
                      MEM_W'(rnd_bits(mw - $urandom_range(0, (mw > 1) ? 1 : 0))));
        end
    endtask

    // Drive command beats; predict each one as it is taken
    always @(posedge aclk) begin : tx_drive
        host_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_to_table(beat_on_bus);
                accepted_beats <= accepted_beats + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt         = pending_beats.pop_front();
                    beat_on_bus = nxt;
                    s_tdata     <= S_TDATA_W'({nxt.req_mem, nxt.req_cpu, nxt.id, nxt.mem,
                                               nxt.cpu, nxt.active, nxt.rank, nxt.idx});
                    s_tuser     <= nxt.cmd;
                    s_tvalid    <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the receiver once for a long stretch so the core backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_beats >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check each result beat against the oldest predicted placement
    always @(posedge aclk) begin : rx_check
        placement_t got;
        placement_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.id     = m_tdata[15:0];
                got.placed = m_tdata[16];
                got.slot   = m_tdata[22:17];
                if (placements.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: id %0d placed %0d slot %0d",
                                 got.id, got.placed, got.slot);
                    end
                end else begin
                    want = placements.pop_front();
                    if (got.id !== want.id || got.placed !== want.placed ||
                        got.slot !== want.slot) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected id %0d placed %0d slot %0d",
                                     want.id, want.placed, want.slot);
                            $display("               got id %0d placed %0d slot %0d",
                                     got.id, got.placed, got.slot);
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, extremes, tie-breaks, reload, clear
        add_place('0, '0, '0);
        add_cmd(CMD_UNUSED);
        add_load(0, RANK_LEVELS - 1, 1'b1, '1, '1);
        add_load(HOST_SLOTS - 1, 0, 1'b1, 40'h100, 24'd10);
        add_load(5, 0, 1'b0, '1, '1);
        add_load(10, 0, 1'b1, 40'h200, 24'd100);
        add_place(16'h0000, 40'h100, 24'd10);
        add_place(16'hFFFF, 40'h100, 24'd10);
        add_place(16'h1234, '0, '0);
        add_load(20, 1, 1'b1, 40'h50, 24'd5);
        add_load(21, 1, 1'b1, 40'h50, 24'd5);
        add_load(10, 2, 1'b0, 40'h1, 24'd1);
        add_place(16'h0021, 40'h50, 24'd5);
        add_place(16'h0022, 40'h50, 24'd5);
        add_place(16'hAAAA, '1, '1);
        add_place(16'h5555, '1, '0);
        add_cmd(CMD_CLEAR);
        add_place(16'h0077, '0, '0);
        add_load(HOST_SLOTS - 1, RANK_LEVELS - 1, 1'b1, '1, '1);
        add_place(16'hFFFF, '1, '1);
        add_place(16'hFFFE, 40'h1, 24'h1);

        // Random traffic, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target) begin
                add_episode();
            end
            while (pending_beats.size() != 0) @(posedge aclk);
        end

        // Drain: last beat taken, all placements answered, then settle
        while (pending_beats.size() != 0 || s_tvalid) @(posedge aclk);
        while (placements.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && placements.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
